// ===== rtl/core/prc_pkg.sv =====
// Shared types, constants and defaults for the pad row cluster scan unit.
package prc_pkg;

  localparam int ADC_W    = 16;
  localparam int SUM_W    = 21;
  localparam int CNT_W    = 6;
  localparam int ROWNUM_W = 5;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_ROWS     = 32;
  localparam int DEF_COLUMNS  = 64;
  localparam int DEF_ADC_BITS = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [ROWNUM_W-1:0] LAST_ROW_RST = 5'd23;
  localparam logic [CNT_W-1:0]    MIN_ROWS_RST = 6'd22;
  localparam logic [CNT_W-1:0]    MAX_GAP_RST  = 6'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAST_ROW = 2'd0,
    CFG_MIN_ROWS = 2'd1,
    CFG_MAX_GAP  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ADC_W-1:0] adc;
    logic                    row_end;
    logic                    event_end;
  } in_req_t;

  typedef struct packed {
    logic                is_summary;
    logic [ROWNUM_W-1:0] row_number;
    logic [SUM_W-1:0]    row_charge;
    logic [CNT_W-1:0]    hit_rows;
    logic [CNT_W-1:0]    rows_in_range;
    logic [CNT_W-1:0]    largest_gap;
    logic                touches_border;
    logic                passed;
    logic                alarm;
    logic                last;
  } out_res_t;

  // One queue entry holds everything that one input item produces.
  typedef struct packed {
    logic                has_row;
    logic                has_sum;
    logic [ROWNUM_W-1:0] row_number;
    logic [SUM_W-1:0]    row_charge;
    logic [CNT_W-1:0]    hit_rows;
    logic [CNT_W-1:0]    rows_in_range;
    logic [CNT_W-1:0]    largest_gap;
    logic                touches_border;
    logic                alarm;
  } queue_entry_t;

endpackage

// ===== rtl/core/prc_front.sv =====
// Front end: accepts pad samples, tracks row and event state, queues results.
module prc_front
  import prc_pkg::*;
#(
  parameter int ROWS     = DEF_ROWS,
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ADC_BITS = DEF_ADC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_req_t             in_data,
  input  logic [ROWNUM_W-1:0] last_row,
  input  logic                queue_full,
  output logic                push,
  output queue_entry_t        push_entry
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int GAP_W = (COL_W > CNT_W) ? COL_W : CNT_W;
  localparam int CMP_W = (ROW_W > ROWNUM_W) ? ROW_W : ROWNUM_W;
  localparam int MAG_W = ADC_W - 1;
  localparam logic [MAG_W-1:0] CLIP     = MAG_W'((1 << (ADC_BITS - 1)) - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  logic [SUM_W-1:0] row_sum_r, row_sum_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] prev_col_r, prev_col_nxt;
  logic             row_hit_r, row_hit_nxt;
  logic [CNT_W-1:0] gap_max_r, gap_max_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0] hit_rows_r, hit_rows_nxt;
  logic [CNT_W-1:0] in_range_r, in_range_nxt;
  logic             border_r, border_nxt;
  logic             alarm_r, alarm_nxt;

  logic             accept;
  logic             neg;
  logic [MAG_W-1:0] pos;
  logic [MAG_W-1:0] mag;
  logic             hit;
  logic             end_row;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] new_sum;
  logic [COL_W-1:0] gap_diff;
  logic [CNT_W-1:0] gap_sat;
  logic [CNT_W-1:0] new_gap_max;
  logic             new_border;
  logic             new_alarm;
  logic             row_out;
  logic [CNT_W-1:0] new_hits;
  logic [CNT_W-1:0] new_in_range;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  assign neg     = in_data.adc[ADC_W-1];
  assign pos     = in_data.adc[MAG_W-1:0];
  assign mag     = neg ? '0 : ((pos > CLIP) ? CLIP : pos);
  assign hit     = (mag != '0);
  assign end_row = in_data.row_end || in_data.event_end;

  assign sum_ext = {1'b0, row_sum_r} + (SUM_W + 1)'(mag);
  assign new_sum = hit ? (sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0]) : row_sum_r;

  assign gap_diff = col_r - prev_col_r - COL_W'(1);
  assign gap_sat  = (GAP_W'(gap_diff) > GAP_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(gap_diff);

  always_comb begin
    new_gap_max = gap_max_r;
    if (hit && row_hit_r && (col_r > prev_col_r) && (gap_sat > gap_max_r)) begin
      new_gap_max = gap_sat;
    end
  end

  assign new_border = border_r || (hit && ((col_r == '0) || end_row));
  assign new_alarm  = alarm_r || neg;

  // A row result goes out when the row closes with charge on it.
  assign row_out      = end_row && (new_sum != '0);
  assign new_hits     = (row_out && (hit_rows_r != CNT_MAX)) ? hit_rows_r + 1'b1 : hit_rows_r;
  assign new_in_range = (row_out && (CMP_W'(row_cnt_r) <= CMP_W'(last_row))
                         && (in_range_r != CNT_MAX)) ? in_range_r + 1'b1 : in_range_r;

  always_comb begin
    row_sum_nxt  = new_sum;
    col_nxt      = (col_r < COL_LAST) ? col_r + 1'b1 : col_r;
    prev_col_nxt = hit ? col_r : prev_col_r;
    row_hit_nxt  = row_hit_r || hit;
    gap_max_nxt  = new_gap_max;
    row_cnt_nxt  = row_cnt_r;
    hit_rows_nxt = new_hits;
    in_range_nxt = new_in_range;
    border_nxt   = new_border;
    alarm_nxt    = new_alarm;
    if (end_row) begin
      row_sum_nxt  = '0;
      col_nxt      = '0;
      prev_col_nxt = '0;
      row_hit_nxt  = 1'b0;
      row_cnt_nxt  = (row_cnt_r < ROW_LAST) ? row_cnt_r + 1'b1 : row_cnt_r;
    end
    if (in_data.event_end) begin
      gap_max_nxt  = '0;
      row_cnt_nxt  = '0;
      hit_rows_nxt = '0;
      in_range_nxt = '0;
      border_nxt   = 1'b0;
      alarm_nxt    = 1'b0;
    end
  end

  assign push = accept && (row_out || in_data.event_end);

  always_comb begin
    push_entry                = '0;
    push_entry.has_row        = row_out;
    push_entry.has_sum        = in_data.event_end;
    push_entry.row_number     = ROWNUM_W'(row_cnt_r);
    push_entry.row_charge     = new_sum;
    push_entry.hit_rows       = new_hits;
    push_entry.rows_in_range  = new_in_range;
    push_entry.largest_gap    = new_gap_max;
    push_entry.touches_border = new_border;
    push_entry.alarm          = new_alarm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sum_r  <= '0;
      col_r      <= '0;
      prev_col_r <= '0;
      row_hit_r  <= 1'b0;
      gap_max_r  <= '0;
      row_cnt_r  <= '0;
      hit_rows_r <= '0;
      in_range_r <= '0;
      border_r   <= 1'b0;
      alarm_r    <= 1'b0;
    end else if (accept) begin
      row_sum_r  <= row_sum_nxt;
      col_r      <= col_nxt;
      prev_col_r <= prev_col_nxt;
      row_hit_r  <= row_hit_nxt;
      gap_max_r  <= gap_max_nxt;
      row_cnt_r  <= row_cnt_nxt;
      hit_rows_r <= hit_rows_nxt;
      in_range_r <= in_range_nxt;
      border_r   <= border_nxt;
      alarm_r    <= alarm_nxt;
    end
  end

endmodule

// ===== rtl/core/prc_queue.sv =====
// Short first-in first-out queue of pending result entries.
module prc_queue
  import prc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output queue_entry_t head_entry,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t      entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_entry = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/prc_back.sv =====
// Back end: turns queued entries into row and summary results.
module prc_back
  import prc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  queue_entry_t     head_entry,
  input  logic             queue_empty,
  output logic             pop,
  input  logic [CNT_W-1:0] min_rows,
  input  logic [CNT_W-1:0] max_gap_allowed,
  output logic             out_valid,
  input  logic             out_stall,
  output out_res_t         out_data
);

  logic     out_valid_r, out_valid_nxt;
  out_res_t out_data_r, out_data_nxt;
  logic     row_sent_r, row_sent_nxt;
  logic     load;
  logic     send_row;

  assign load     = !queue_empty && (!out_valid_r || !out_stall);
  assign send_row = head_entry.has_row && !row_sent_r;

  always_comb begin
    out_data_nxt  = '0;
    pop           = 1'b0;
    row_sent_nxt  = row_sent_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (send_row) begin
        out_data_nxt.row_number = head_entry.row_number;
        out_data_nxt.row_charge = head_entry.row_charge;
        out_data_nxt.last       = !head_entry.has_sum;
        pop                     = !head_entry.has_sum;
        row_sent_nxt            = head_entry.has_sum;
      end else begin
        out_data_nxt.is_summary     = 1'b1;
        out_data_nxt.hit_rows       = head_entry.hit_rows;
        out_data_nxt.rows_in_range  = head_entry.rows_in_range;
        out_data_nxt.largest_gap    = head_entry.largest_gap;
        out_data_nxt.touches_border = head_entry.touches_border;
        out_data_nxt.passed         = (head_entry.hit_rows >= min_rows)
                                      && (head_entry.largest_gap <= max_gap_allowed);
        out_data_nxt.alarm          = head_entry.alarm;
        out_data_nxt.last           = 1'b1;
        pop                         = 1'b1;
        row_sent_nxt                = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_sent_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      row_sent_r  <= row_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/pad_row_cluster_scan_unit.sv =====
// Top level of the pad row cluster scan unit: configuration registers and block wiring.
//
// The unit takes one pad charge sample per request on the input channel
// (in_valid, in_stall, in_data) and counts columns and rows on its own. A
// sample flagged row_end closes its row; event_end closes the row and the
// event. Each closed row with charge gives a row result, and each event end
// gives a summary result, on the output channel (out_valid, out_stall,
// out_data). The last flag marks the final result caused by one sample.
// Throughput is one sample per cycle while the queue is not full. Results
// leave at one per cycle while out_stall is low, so an event end that also
// closes a hit row gives two results. The front end updates the row state
// and writes a four-entry queue in the accept cycle, and the back end then
// loads the output register from the queue head. When the receiver stalls,
// the output register holds its result, the queue fills, and in_stall rises
// only once the queue is full. The configuration port (cfg_we, cfg_index,
// cfg_data) writes last_row, min_rows and max_gap_allowed; the user must use
// it only while the unit is idle, and the block itself does not enforce
// this. Reset (rst_n low at a clock edge) clears all row and event state,
// empties the queue and the output register, and loads the register defaults.
module pad_row_cluster_scan_unit
  import prc_pkg::*;
#(
  parameter int ROWS     = DEF_ROWS,
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ADC_BITS = DEF_ADC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_res_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Selection registers; the user must write them only between events, the block does not enforce this.
  logic [ROWNUM_W-1:0] last_row_r;
  logic [CNT_W-1:0]    min_rows_r;
  logic [CNT_W-1:0]    max_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= LAST_ROW_RST;
      min_rows_r <= MIN_ROWS_RST;
      max_gap_r  <= MAX_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAST_ROW: last_row_r <= cfg_data[ROWNUM_W-1:0];
        CFG_MIN_ROWS: min_rows_r <= cfg_data[CNT_W-1:0];
        CFG_MAX_GAP:  max_gap_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The queue between front and back lets each side stall on its own.
  logic         push;
  queue_entry_t push_entry;
  logic         pop;
  queue_entry_t head_entry;
  logic         queue_full;
  logic         queue_empty;

  prc_front #(
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS),
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .last_row   (last_row_r),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  prc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  prc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_entry      (head_entry),
    .queue_empty     (queue_empty),
    .pop             (pop),
    .min_rows        (min_rows_r),
    .max_gap_allowed (max_gap_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

endmodule
